FILE: sv/iwr_pkg.sv
// Shared types and constants for the instruction window ring.
// No dependencies; imported by iwr_cell and instruction_window_ring.
`default_nettype none

package iwr_pkg;

   localparam int DEPTH_DEF        = 128;
   localparam int RETIRE_WIDTH_DEF = 4;
   localparam int ADDR_W_DEF       = 48;

   localparam int OP_W      = 2;
   localparam int CSR_W     = 4;
   localparam int RETIRED_W = 3;
   localparam int OCC_W     = 8;

   localparam logic [CSR_W-1:0] CSR_RESET = 4'd6;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT    = 2'd0,
      OP_RETIRE    = 2'd1,
      OP_SET_READY = 2'd2
   } iwr_op_type;

   // per-cycle command broadcast along the cell chain
   typedef struct packed {
      logic insert;
      logic ready_now;
      logic shift;
      logic mark;
   } iwr_cell_ctl_type;

endpackage

`default_nettype wire

FILE: sv/iwr_cell.sv
// One window entry: ready bit and address, shifted toward the tail on retire.
// Depends on iwr_pkg.
`default_nettype none

module iwr_cell #(
   parameter int ADDR_W = iwr_pkg::ADDR_W_DEF,
   parameter int CNT_W  = 8,
   parameter int INDEX  = 0
) (
   input  wire                            clock,
   input  iwr_pkg::iwr_cell_ctl_type      ctl,
   input  wire  [CNT_W-1:0]               count,
   input  wire  [ADDR_W-1:0]              keep_mask,
   input  wire  [ADDR_W-1:0]              in_address,
   input  wire                            up_ready,
   input  wire  [ADDR_W-1:0]              up_address,
   output logic                           ready_q,
   output logic [ADDR_W-1:0]              address_q
);
   import iwr_pkg::*;

   localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

   logic              ready_ff, ready_in;
   logic [ADDR_W-1:0] address_ff, address_in;
   logic              occupied;
   logic              match;

   assign occupied = MY_IDX < count;
   assign match    = (address_ff & keep_mask) == (in_address & keep_mask);

   always_comb begin
      ready_in   = ready_ff;
      address_in = address_ff;
      if (ctl.shift) begin
         ready_in   = up_ready;
         address_in = up_address;
      end else if (ctl.insert && count == MY_IDX) begin
         ready_in   = ctl.ready_now;
         address_in = in_address;
      end else if (ctl.mark && occupied && match) begin
         ready_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      ready_ff   <= ready_in;
      address_ff <= address_in;
   end

   assign ready_q   = ready_ff;
   assign address_q = address_ff;

endmodule

`default_nettype wire

FILE: sv/instruction_window_ring.sv
// Instruction window kept as a chain of entry cells, oldest entry in cell 0.
// Depends on iwr_pkg and iwr_cell.
//
//   channel | ports                                   | role
//   req     | req_valid/req_ready, op, ready_now, addr | insert, retire, set-ready
//   rsp     | rsp_valid/rsp_ready, count and flags     | one word per request
//   csr     | csr_valid/csr_ready, block_offset_bits   | match granularity
//
// Insert, set-ready and unused ops load their result word when accepted; retire removes
// at most RETIRE_WIDTH entries, one cell shift per cycle, then loads its result word.
// Set-ready compares all occupied cells in parallel in the accept cycle.
// A new request is taken while the result word waits if rsp_ready is high.
// Reset empties the window and sets block_offset_bits to 6; req_ready and
// csr_ready are low during reset, csr_ready is high otherwise.
`default_nettype none

module instruction_window_ring #(
   parameter int DEPTH        = iwr_pkg::DEPTH_DEF,
   parameter int RETIRE_WIDTH = iwr_pkg::RETIRE_WIDTH_DEF,
   parameter int ADDR_W       = iwr_pkg::ADDR_W_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire  [iwr_pkg::OP_W-1:0]         req_op,
   input  wire                              req_ready_now,
   input  wire  [ADDR_W-1:0]                req_address,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic [iwr_pkg::RETIRED_W-1:0]    rsp_retired_count,
   output logic [iwr_pkg::OCC_W-1:0]        rsp_occupancy,
   output logic                             rsp_is_full_now,
   output logic                             rsp_is_empty_now,
   output logic                             rsp_overflow,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [iwr_pkg::CSR_W-1:0]        csr_block_offset_bits
);
   import iwr_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int RET_W = $clog2(RETIRE_WIDTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
   localparam logic [RET_W-1:0] MAX_RET  = RET_W'(RETIRE_WIDTH);

   typedef enum logic {S_IDLE, S_RETIRE} state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [RET_W-1:0]      retired_ff, retired_in;
   logic [CSR_W-1:0]      csr_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RETIRED_W-1:0]  rsp_retired_ff, rsp_retired_in;
   logic [OCC_W-1:0]      rsp_occ_ff, rsp_occ_in;
   logic                  rsp_full_ff, rsp_full_in;
   logic                  rsp_empty_ff, rsp_empty_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;

   iwr_cell_ctl_type      ctl;
   logic                  accept;
   logic                  load_rsp;
   logic                  ovf;
   logic [RET_W-1:0]      ret_report;
   logic [ADDR_W-1:0]     keep_mask;

   logic                  cell_ready   [DEPTH];
   logic [ADDR_W-1:0]     cell_address [DEPTH];

   assign keep_mask = {ADDR_W{1'b1}} << csr_ff;
   assign req_ready = !reset && (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign csr_ready = !reset;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic              up_ready;
      logic [ADDR_W-1:0] up_address;
      if (i == DEPTH - 1) begin : g_last
         assign up_ready   = 1'b0;
         assign up_address = '0;
      end else begin : g_mid
         assign up_ready   = cell_ready[i+1];
         assign up_address = cell_address[i+1];
      end
      iwr_cell #(
         .ADDR_W    (ADDR_W),
         .CNT_W     (CNT_W),
         .INDEX     (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .count      (count_ff),
         .keep_mask  (keep_mask),
         .in_address (req_address),
         .up_ready   (up_ready),
         .up_address (up_address),
         .ready_q    (cell_ready[i]),
         .address_q  (cell_address[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      retired_in   = retired_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ctl          = '0;
      load_rsp     = 1'b0;
      ovf          = 1'b0;
      ret_report   = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_INSERT: begin
                     load_rsp = 1'b1;
                     if (count_ff == FULL_CNT) begin
                        ovf = 1'b1;
                     end else begin
                        ctl.insert    = 1'b1;
                        ctl.ready_now = req_ready_now;
                        count_in      = count_ff + 1'b1;
                     end
                  end
                  OP_RETIRE: begin
                     state_in   = S_RETIRE;
                     retired_in = '0;
                  end
                  OP_SET_READY: begin
                     ctl.mark = 1'b1;
                     load_rsp = 1'b1;
                  end
                  default: begin
                     load_rsp = 1'b1;
                  end
               endcase
            end
         end
         S_RETIRE: begin
            if (count_ff != '0 && cell_ready[0] && retired_ff != MAX_RET) begin
               ctl.shift  = 1'b1;
               count_in   = count_ff - 1'b1;
               retired_in = retired_ff + 1'b1;
            end else begin
               load_rsp   = 1'b1;
               ret_report = retired_ff;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_retired_in = rsp_retired_ff;
      rsp_occ_in     = rsp_occ_ff;
      rsp_full_in    = rsp_full_ff;
      rsp_empty_in   = rsp_empty_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      if (load_rsp) begin
         rsp_valid_in   = 1'b1;
         rsp_retired_in = RETIRED_W'(ret_report);
         rsp_occ_in     = OCC_W'(count_in);
         rsp_full_in    = count_in == FULL_CNT;
         rsp_empty_in   = count_in == '0;
         rsp_ovf_in     = ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         retired_ff   <= '0;
         csr_ff       <= CSR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         retired_ff   <= retired_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            csr_ff <= csr_block_offset_bits;
         end
      end
      rsp_retired_ff <= rsp_retired_in;
      rsp_occ_ff     <= rsp_occ_in;
      rsp_full_ff    <= rsp_full_in;
      rsp_empty_ff   <= rsp_empty_in;
      rsp_ovf_ff     <= rsp_ovf_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_retired_count = rsp_retired_ff;
   assign rsp_occupancy     = rsp_occ_ff;
   assign rsp_is_full_now   = rsp_full_ff;
   assign rsp_is_empty_now  = rsp_empty_ff;
   assign rsp_overflow      = rsp_ovf_ff;

endmodule

`default_nettype wire

FILE: sim/iwr_window_check.sv
// Checker for the instruction window ring: watches the req, rsp and csr channels,
// predicts every status word and compares it with the block's output.
// Depends on iwr_pkg; instantiated beside the DUT by instruction_window_ring_tb.
module iwr_window_check #(
   parameter int DEPTH        = iwr_pkg::DEPTH_DEF,
   parameter int RETIRE_WIDTH = iwr_pkg::RETIRE_WIDTH_DEF,
   parameter int ADDR_W       = iwr_pkg::ADDR_W_DEF
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   input  wire                           req_ready,
   input  wire  [iwr_pkg::OP_W-1:0]      req_op,
   input  wire                           req_ready_now,
   input  wire  [ADDR_W-1:0]             req_address,
   input  wire                           rsp_valid,
   input  wire                           rsp_ready,
   input  wire  [iwr_pkg::RETIRED_W-1:0] rsp_retired_count,
   input  wire  [iwr_pkg::OCC_W-1:0]     rsp_occupancy,
   input  wire                           rsp_is_full_now,
   input  wire                           rsp_is_empty_now,
   input  wire                           rsp_overflow,
   input  wire                           csr_valid,
   input  wire                           csr_ready,
   input  wire  [iwr_pkg::CSR_W-1:0]     csr_block_offset_bits,
   output int                            mismatches,
   output int                            outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import iwr_pkg::*;

   localparam int DUE_DEPTH = 16;

   typedef struct packed {
      logic [RETIRED_W-1:0] retired;
      logic [OCC_W-1:0]     occupancy;
      logic                 full;
      logic                 empty;
      logic                 overflow;
   } window_status_type;

   bit                   slot_ready [DEPTH];
   logic [ADDR_W-1:0]    slot_addr  [DEPTH];
   int unsigned          head_idx;
   int unsigned          tail_idx;
   int unsigned          held;
   logic [CSR_W-1:0]     match_offset;
   window_status_type    due_fifo [DUE_DEPTH];
   logic [3:0]           due_wr;
   logic [3:0]           due_rd;
   int                   due_cnt;

   function automatic window_status_type apply_window_op(input logic [OP_W-1:0] op,
                                                        input logic rdy,
                                                        input logic [ADDR_W-1:0] addr);
      window_status_type    s;
      logic [63:0]          keep64;
      logic [ADDR_W-1:0]    keep;
      int unsigned          idx;
      int unsigned          removed;
      s       = '0;
      removed = 0;
      case (op)
         OP_INSERT: begin
            if (held >= DEPTH) begin
               s.overflow = 1'b1;
            end else begin
               slot_ready[head_idx] = rdy;
               slot_addr[head_idx]  = addr;
               head_idx = (head_idx + 1) % DEPTH;
               held++;
            end
         end
         OP_RETIRE: begin
            while (held > 0 && removed < RETIRE_WIDTH && slot_ready[tail_idx]) begin
               tail_idx = (tail_idx + 1) % DEPTH;
               held--;
               removed++;
            end
         end
         OP_SET_READY: begin
            keep64 = ~((64'd1 << match_offset) - 64'd1);
            keep   = keep64[ADDR_W-1:0];
            for (int i = 0; i < held; i++) begin
               idx = (tail_idx + i) % DEPTH;
               if ((slot_addr[idx] & keep) == (addr & keep))
                  slot_ready[idx] = 1'b1;
            end
         end
         default: ;
      endcase
      s.retired   = RETIRED_W'(removed);
      s.occupancy = OCC_W'(held);
      s.full      = (held == DEPTH);
      s.empty     = (held == 0);
      return s;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      window_status_type want;
      if (reset) begin
         head_idx     = 0;
         tail_idx     = 0;
         held         = 0;
         match_offset = CSR_RESET;
         due_wr       = '0;
         due_rd       = '0;
         due_cnt      = 0;
      end else begin
         if (req_valid && req_ready) begin
            if (due_cnt == DUE_DEPTH) begin
               $error("more request words outstanding than tracked");
               mismatches++;
            end else begin
               due_fifo[due_wr] = apply_window_op(req_op, req_ready_now, req_address);
               due_wr = due_wr + 4'd1;
               due_cnt++;
            end
         end
         if (csr_valid && csr_ready)
            match_offset = csr_block_offset_bits;
         if (rsp_valid && rsp_ready) begin
            if (due_cnt == 0) begin
               $error("rsp word with no request outstanding");
               mismatches++;
            end else begin
               want   = due_fifo[due_rd];
               due_rd = due_rd + 4'd1;
               due_cnt--;
               check_field("retired_count", 8'(want.retired), 8'(rsp_retired_count));
               check_field("occupancy", want.occupancy, rsp_occupancy);
               check_field("is_full_now", 8'(want.full), 8'(rsp_is_full_now));
               check_field("is_empty_now", 8'(want.empty), 8'(rsp_is_empty_now));
               check_field("overflow", 8'(want.overflow), 8'(rsp_overflow));
            end
         end
      end
      outstanding = due_cnt;
   end

endmodule

FILE: sim/instruction_window_ring_tb.sv
// Top of the instruction window ring testbench: clock, reset, directed and random
// request words, csr writes and rsp back-pressure; gives the verdict.
// Depends on iwr_pkg, instruction_window_ring and iwr_window_check.
module instruction_window_ring_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import iwr_pkg::*;

   localparam int               AW          = ADDR_W_DEF;
   localparam logic [OP_W-1:0]  OP_UNUSED   = 2'd3;
   localparam int               CYCLE_LIMIT = 1000000;
   localparam int               PHASES      = 6;

   typedef enum int {MIX_FILL, MIX_EVEN, MIX_DRAIN} mix_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [OP_W-1:0]      req_op;
   logic                 req_ready_now;
   logic [AW-1:0]        req_address;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [RETIRED_W-1:0] rsp_retired_count;
   logic [OCC_W-1:0]     rsp_occupancy;
   logic                 rsp_is_full_now;
   logic                 rsp_is_empty_now;
   logic                 rsp_overflow;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_W-1:0]     csr_block_offset_bits;

   int                   mismatches;
   int                   outstanding;
   int                   cycle_count;
   bit                   calm_run;
   int                   hold_asks;
   logic [CSR_W-1:0]     cur_off;
   logic [AW-1:0]        recent_addr [256];
   int                   recent_wr;

   instruction_window_ring DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_op                (req_op),
      .req_ready_now         (req_ready_now),
      .req_address           (req_address),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_retired_count     (rsp_retired_count),
      .rsp_occupancy         (rsp_occupancy),
      .rsp_is_full_now       (rsp_is_full_now),
      .rsp_is_empty_now      (rsp_is_empty_now),
      .rsp_overflow          (rsp_overflow),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_block_offset_bits (csr_block_offset_bits)
   );

   iwr_window_check CHECK (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_op                (req_op),
      .req_ready_now         (req_ready_now),
      .req_address           (req_address),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_retired_count     (rsp_retired_count),
      .rsp_occupancy         (rsp_occupancy),
      .rsp_is_full_now       (rsp_is_full_now),
      .rsp_is_empty_now      (rsp_is_empty_now),
      .rsp_overflow          (rsp_overflow),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_block_offset_bits (csr_block_offset_bits),
      .mismatches            (mismatches),
      .outstanding           (outstanding)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int idle_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 65)
         return 0;
      else if (p < 95)
         return $urandom_range(1, 4);
      return $urandom_range(15, 60);
   endfunction

   function automatic logic [AW-1:0] rand_addr();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      return r[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] low_mask();
      return (48'd1 << cur_off) - 48'd1;
   endfunction

   function automatic logic [AW-1:0] recent_pick();
      int back;
      back = $urandom_range(0, 159);
      if (recent_wr == 0)
         return rand_addr();
      return recent_addr[(recent_wr - 1 - back) & 255];
   endfunction

   function automatic logic [AW-1:0] insert_addr();
      int p;
      p = $urandom_range(0, 99);
      if (p < 40)
         return rand_addr();
      else if (p < 80)
         return recent_pick() ^ (rand_addr() & low_mask());
      return {40'd0, 8'($urandom_range(0, 255))};
   endfunction

   function automatic logic [AW-1:0] completion_addr();
      int p;
      p = $urandom_range(0, 99);
      if (p < 65)
         return recent_pick() ^ (rand_addr() & low_mask());
      else if (p < 80)
         return recent_pick() ^ (48'd1 << $urandom_range(cur_off, AW - 1));
      return rand_addr();
   endfunction

   // rsp side: random stalls, or one long hold-off on request
   initial begin
      int n;
      int hold_done;
      rsp_ready = 1'b0;
      hold_done = 0;
      forever begin
         @(negedge clock);
         if (hold_asks != hold_done) begin
            hold_done = hold_asks;
            rsp_ready <= 1'b0;
            repeat (299) @(negedge clock);
         end else begin
            n = calm_run ? 0 : idle_len();
            if (n == 0) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready <= 1'b0;
               repeat (n - 1) @(negedge clock);
            end
         end
      end
   end

   task automatic send_word(input logic [OP_W-1:0] op, input logic rdy, input logic [AW-1:0] addr);
      int n;
      n = calm_run ? 0 : idle_len();
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_op        <= op;
      req_ready_now <= rdy;
      req_address   <= addr;
      do @(posedge clock); while (req_ready !== 1'b1);
   endtask

   task automatic insert_word(input logic rdy, input logic [AW-1:0] addr);
      recent_addr[recent_wr & 255] = addr;
      recent_wr++;
      send_word(OP_INSERT, rdy, addr);
   endtask

   task automatic random_word(input mix_type mix);
      int              p;
      int              ins_w;
      int              ret_w;
      int              set_w;
      logic [OP_W-1:0] op;
      case (mix)
         MIX_FILL: begin
            ins_w = 70; ret_w = 15; set_w = 13;
         end
         MIX_EVEN: begin
            ins_w = 40; ret_w = 30; set_w = 27;
         end
         default: begin
            ins_w = 15; ret_w = 45; set_w = 37;
         end
      endcase
      p = $urandom_range(0, 99);
      if (p < ins_w)
         op = OP_INSERT;
      else if (p < ins_w + ret_w)
         op = OP_RETIRE;
      else if (p < ins_w + ret_w + set_w)
         op = OP_SET_READY;
      else
         op = OP_UNUSED;
      if (op == OP_INSERT)
         insert_word($urandom_range(0, 99) < 35, insert_addr());
      else if (op == OP_SET_READY)
         send_word(op, $urandom_range(0, 1), completion_addr());
      else
         send_word(op, $urandom_range(0, 1), rand_addr());
   endtask

   // wait until every word sent so far has its status back
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic write_offset(input logic [CSR_W-1:0] v);
      @(negedge clock);
      csr_valid             <= 1'b1;
      csr_block_offset_bits <= v;
      do @(posedge clock); while (csr_ready !== 1'b1);
      @(negedge clock);
      csr_valid <= 1'b0;
      cur_off = v;
   endtask

   initial begin
      logic [CSR_W-1:0] phase_off [PHASES];
      reset                 = 1'b1;
      req_valid             = 1'b0;
      req_op                = OP_INSERT;
      req_ready_now         = 1'b0;
      req_address           = '0;
      csr_valid             = 1'b0;
      csr_block_offset_bits = CSR_RESET;
      calm_run              = 1'b0;
      cur_off               = CSR_RESET;
      recent_wr             = 0;
      foreach (recent_addr[i]) recent_addr[i] = '0;
      phase_off = '{4'd0, 4'd15, 4'd12, 4'd6, 4'd13, 4'($urandom_range(0, 15))};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty-window cases, retire stopping and width cap, matching
      send_word(OP_RETIRE, 1'b0, '0);
      send_word(OP_SET_READY, 1'b0, '0);
      send_word(OP_UNUSED, 1'b1, '1);
      insert_word(1'b0, '1);
      insert_word(1'b1, '0);
      insert_word(1'b0, 48'h0000_0000_003F);
      send_word(OP_RETIRE, 1'b1, '0);
      send_word(OP_SET_READY, 1'b0, 48'hFFFF_FFFF_FFC0);
      send_word(OP_RETIRE, 1'b0, '1);
      send_word(OP_SET_READY, 1'b1, 48'h0000_0000_0007);
      insert_word(1'b1, 48'h0000_0000_1000);
      insert_word(1'b1, 48'h0000_0000_2000);
      insert_word(1'b1, 48'h0000_0000_3000);
      insert_word(1'b1, 48'hAAAA_5555_0000);
      send_word(OP_UNUSED, 1'b0, 48'h5555_AAAA_FFFF);
      send_word(OP_RETIRE, 1'b0, '0);
      send_word(OP_RETIRE, 1'b0, '0);
      send_word(OP_RETIRE, 1'b0, '0);

      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         write_offset(phase_off[ph]);
         if (ph == 1) begin
            // fill past full so inserts overflow
            repeat (140) insert_word($urandom_range(0, 1), insert_addr());
         end
         if (ph == 2) begin
            hold_asks++;
            calm_run = 1'b1;
            repeat (40) random_word(MIX_FILL);
            calm_run = 1'b0;
         end
         for (int k = 0; k < 135; k++) begin
            calm_run = (ph == 4 && k < 60);
            random_word(mix_type'(ph % 3));
         end
         calm_run = 1'b0;
      end

      settle();
      repeat (10) @(negedge clock);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
